// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define AR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocator check failed");
// condition never seen outside reset
`define AR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("allocator forbidden condition");
`else
`define AR_ASSERT(label, clk, rst_n, prop)
`define AR_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/ara_pkg.sv =====
// shared types and constants of the address range allocator
// no dependencies; imported by every allocator module
package ara_pkg;

    localparam int PAGE_BITS   = 36;
    localparam int MAX_RANGES  = 64;
    localparam int CFG_W       = 36;
    localparam int ORD_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int IDX_W       = $clog2(MAX_RANGES);
    localparam int CNT_W       = $clog2(MAX_RANGES + 1);
    localparam int ABS_W       = ((PAGE_BITS > CFG_W) ? PAGE_BITS : CFG_W) + 2;
    localparam longint SIZE_RESET = 64'd1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_NO_GAP  = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    // commands from the controller
    typedef struct packed {
        logic    latch;
        logic    pre;
        logic    ld;
        logic    ev;
        logic    walk;
        logic    idx_inc;
        logic    grant;
        logic    shift;
        logic    put;
        logic    fail;
        t_status code;
        logic    addr_up;
    } t_cmd;

    // status back from the datapath
    typedef struct packed {
        logic zero_n;
        logic op;
        logic spec_bad;
        logic idx_zero;
        logic idx_at_count;
        logic hit;
        logic fit;
        logic more;
        logic full;
    } t_dp_stat;

endpackage

// ===== rtl/core/ara_dp.sv =====
// allocator datapath: config registers, range table memory, walk arithmetic
// depends on ara_pkg and assert_macros.svh
`include "assert_macros.svh"
module ara_dp import ara_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_operation,
    input  logic [PAGE_BITS-1:0] i_requested_page_offset,
    input  logic [PAGE_BITS-1:0] i_request_page_count,
    input  logic [ORD_W-1:0]     i_align_order,
    output logic [1:0]           o_status,
    output logic [PAGE_BITS-1:0] o_granted_page_offset,
    output logic [CNT_W-1:0]     o_ranges_in_use
);

    logic [CFG_W-1:0]     r_base;
    logic [CFG_W-1:0]     r_size;
    logic                 r_op;
    logic [PAGE_BITS-1:0] r_o;
    logic [PAGE_BITS-1:0] r_n;
    logic [ORD_W-1:0]     r_ord;
    logic [ABS_W-1:0]     r_on;
    logic [ABS_W-1:0]     r_acc;
    logic [ABS_W-1:0]     r_top;
    logic [ABS_W-1:0]     r_btop;
    logic [ABS_W-1:0]     r_st;
    logic [ABS_W-1:0]     r_en;
    logic [ABS_W-1:0]     r_gap;
    logic [ABS_W-1:0]     r_cand;
    logic [ABS_W-1:0]     r_ben;
    logic                 r_hit;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic [PAGE_BITS-1:0] r_grant;
    t_status              r_status;

    logic [PAGE_BITS-1:0] r_mem_st  [MAX_RANGES];
    logic [PAGE_BITS-1:0] r_mem_len [MAX_RANGES];
    logic [PAGE_BITS-1:0] r_rd_st;
    logic [PAGE_BITS-1:0] r_rd_len;

    logic [ABS_W-1:0]     w_base;
    logic [ABS_W-1:0]     w_n;
    logic [ABS_W-1:0]     w_lowmask;
    logic [CNT_W-1:0]     w_idx_m1;
    logic [IDX_W-1:0]     w_raddr;
    logic                 w_virt;
    logic                 w_we;
    logic [PAGE_BITS-1:0] w_wst;
    logic [PAGE_BITS-1:0] w_wlen;

    assign w_base    = ABS_W'(r_base);
    assign w_n       = ABS_W'(r_n);
    assign w_lowmask = (ABS_W'(1) << r_ord) - ABS_W'(1);
    assign w_idx_m1  = r_idx - CNT_W'(1);
    assign w_raddr   = i_cmd.addr_up ? r_idx[IDX_W-1:0] : w_idx_m1[IDX_W-1:0];
    // below the lowest stored range the walk sees an empty range at zero
    assign w_virt    = !r_op && (r_idx == '0);

    assign w_we   = i_cmd.shift || i_cmd.put;
    assign w_wst  = i_cmd.shift ? r_rd_st  : r_grant;
    assign w_wlen = i_cmd.shift ? r_rd_len : r_n;

    always_comb begin
        o_stat              = '0;
        o_stat.zero_n       = (r_n == '0);
        o_stat.op           = r_op;
        o_stat.spec_bad     = ((r_acc & w_lowmask) != '0) || (r_on > ABS_W'(r_size));
        o_stat.idx_zero     = (r_idx == '0);
        o_stat.idx_at_count = (r_idx == r_count);
        o_stat.hit          = r_hit;
        o_stat.fit          = !r_gap[ABS_W-1] && (r_gap >= w_n) && (r_cand >= r_ben);
        o_stat.more         = (r_rd_st > r_grant);
        o_stat.full         = (r_count == CNT_W'(MAX_RANGES));
    end

    // range table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_st[r_idx[IDX_W-1:0]]  <= w_wst;
            r_mem_len[r_idx[IDX_W-1:0]] <= w_wlen;
        end
        r_rd_st  <= r_mem_st[w_raddr];
        r_rd_len <= r_mem_len[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_size   <= CFG_W'(SIZE_RESET);
            r_count  <= '0;
            r_status <= STS_OK;
            r_grant  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_SIZE: r_size <= i_cfg_data;
                    default:  r_base <= r_base;
                endcase
            end
            if (i_cmd.grant)
                r_grant <= r_op ? r_o : PAGE_BITS'(r_cand - w_base);
            if (i_cmd.put) begin
                r_count  <= r_count + CNT_W'(1);
                r_status <= STS_OK;
            end
            if (i_cmd.fail) begin
                r_status <= i_cmd.code;
                r_grant  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_operation;
            r_o   <= i_requested_page_offset;
            r_n   <= i_request_page_count;
            r_ord <= i_align_order;
        end
        if (i_cmd.pre) begin
            r_on   <= ABS_W'(r_o) + w_n;
            r_acc  <= w_base + ABS_W'(r_o);
            r_top  <= ABS_W'(r_size);
            r_btop <= w_base + ABS_W'(r_size);
            r_idx  <= r_op ? '0 : r_count;
        end
        if (i_cmd.ld) begin
            r_st <= w_virt ? '0 : ABS_W'(r_rd_st);
            r_en <= w_virt ? '0 : ABS_W'(r_rd_st) + ABS_W'(r_rd_len);
        end
        if (i_cmd.ev) begin
            r_gap  <= r_top - r_en;
            r_cand <= (r_btop - w_n) & ~w_lowmask;
            r_ben  <= w_base + r_en;
            r_hit  <= (ABS_W'(r_o) < r_en) && (r_st < r_on);
        end
        if (i_cmd.walk) begin
            if (r_st < r_top) begin
                r_top  <= r_st;
                r_btop <= w_base + r_st;
            end
            r_idx <= w_idx_m1;
        end
        if (i_cmd.idx_inc)
            r_idx <= r_idx + CNT_W'(1);
        if (i_cmd.grant)
            r_idx <= r_count;
        if (i_cmd.shift)
            r_idx <= w_idx_m1;
    end

    assign o_status              = r_status;
    assign o_granted_page_offset = r_grant;
    assign o_ranges_in_use       = r_count;

    `AR_ASSERT(a_put_room, i_clk, i_rst_n, i_cmd.put |-> (r_count < CNT_W'(MAX_RANGES)))
    `AR_ASSERT(a_count_step, i_clk, i_rst_n, (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CNT_W'(1)))
    `AR_NEVER(a_shift_floor, i_clk, i_rst_n, i_cmd.shift && (r_idx == '0))

endmodule

// ===== rtl/core/ara_ctrl.sv =====
// allocator controller: sequences check, walk, insert and result strobe
// depends on ara_pkg and assert_macros.svh
`include "assert_macros.svh"
module ara_ctrl import ara_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_cfg_ready,
    output logic     o_result_valid,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_PRE    = 11'b000_0000_0010,
        ST_CHK    = 11'b000_0000_0100,
        ST_RD     = 11'b000_0000_1000,
        ST_LD     = 11'b000_0001_0000,
        ST_EV     = 11'b000_0010_0000,
        ST_DEC    = 11'b000_0100_0000,
        ST_GRANT  = 11'b000_1000_0000,
        ST_INS_RD = 11'b001_0000_0000,
        ST_INS_LD = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.code = STS_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_PRE;
                end
            end
            ST_PRE: begin
                o_cmd.pre = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                if (i_stat.zero_n || (i_stat.op && i_stat.spec_bad)) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.code = STS_INVALID;
                    n_state    = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.addr_up = i_stat.op;
                if (i_stat.op && i_stat.idx_at_count) begin
                    n_state = ST_GRANT;
                end else begin
                    n_state = ST_LD;
                end
            end
            ST_LD: begin
                o_cmd.ld = 1'b1;
                n_state  = ST_EV;
            end
            ST_EV: begin
                o_cmd.ev = 1'b1;
                n_state  = ST_DEC;
            end
            ST_DEC: begin
                if (i_stat.op) begin
                    if (i_stat.hit) begin
                        o_cmd.fail = 1'b1;
                        o_cmd.code = STS_INVALID;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_RD;
                    end
                end else if (i_stat.fit) begin
                    n_state = ST_GRANT;
                end else if (i_stat.idx_zero) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.code = STS_NO_GAP;
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                    n_state    = ST_RD;
                end
            end
            ST_GRANT: begin
                if (i_stat.full) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.code = STS_FULL;
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.grant = 1'b1;
                    n_state     = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.put = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_INS_LD;
                end
            end
            ST_INS_LD: begin
                if (i_stat.more) begin
                    o_cmd.shift = 1'b1;
                    n_state     = ST_INS_RD;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_result_valid = (r_state == ST_DONE);

    `AR_ASSERT(a_done_to_idle, i_clk, i_rst_n, (r_state == ST_DONE) |=> (r_state == ST_IDLE))
    `AR_ASSERT(a_accept_pre, i_clk, i_rst_n, (start && !busy) |=> (r_state == ST_PRE))
    `AR_NEVER(a_fail_and_put, i_clk, i_rst_n, o_cmd.fail && o_cmd.put)

endmodule

// ===== rtl/core/address_range_allocator_top.sv =====
// top level of the address range allocator
// depends on ara_pkg, ara_ctrl and ara_dp
//
// page range allocator for one region: a request is taken when start is high
// and busy is low, and exactly one result comes back later on o_status,
// o_granted_page_offset and o_ranges_in_use, valid for the single cycle in
// which o_result_valid is high; there is no back-pressure, so the receiver
// must capture it in that cycle. one request is handled at a time. a request
// first passes set-up and the zero-count check, plus the alignment and
// region-end checks for a given offset; a request that fails them goes
// straight to the result strobe. a given offset request then scans the
// stored ranges for overlap, one table step each, and fails at the first
// overlap; else one more read finds the end of the table. a highest-gap
// request walks down from the top, one step per stored range visited and
// one more for the gap below the lowest range. a granted request goes
// through the grant and the full-table check, then a read and a write for
// each stored range that moves up to make room in the sorted table, then
// writes the new entry (after a further read unless every range moves); the
// result strobe comes last. each step is the registered table read followed
// by the end, gap and compare stages of the walk datapath.
// the region base and size registers are written through the config channel,
// accepted only while the block is idle (o_cfg_ready high)
module address_range_allocator_top import ara_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_operation,
    input  logic [PAGE_BITS-1:0] i_requested_page_offset,
    input  logic [PAGE_BITS-1:0] i_request_page_count,
    input  logic [ORD_W-1:0]     i_align_order,
    output logic                 o_result_valid,
    output logic [1:0]           o_status,
    output logic [PAGE_BITS-1:0] o_granted_page_offset,
    output logic [CNT_W-1:0]     o_ranges_in_use
);

    // controller to datapath commands and status flags
    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_cfg_we;

    // register write request completes on valid and ready together
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    ara_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_cfg_ready    (o_cfg_ready),
        .o_result_valid (o_result_valid),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd)
    );

    // table memory, walk arithmetic and result registers
    ara_dp u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_stat                  (w_stat),
        .i_cfg_we                (w_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_operation             (i_operation),
        .i_requested_page_offset (i_requested_page_offset),
        .i_request_page_count    (i_request_page_count),
        .i_align_order           (i_align_order),
        .o_status                (o_status),
        .o_granted_page_offset   (o_granted_page_offset),
        .o_ranges_in_use         (o_ranges_in_use)
    );

endmodule

// ===== bench/address_range_allocator_top_test.sv =====
// self-checking bench for the address range allocator top level
// depends on ara_pkg and address_range_allocator_top; holds its own placement predictor
`timescale 1ns / 1ps

module address_range_allocator_top_test;
    import ara_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    typedef longint unsigned u64;

    typedef struct {
        logic                 op;
        logic [PAGE_BITS-1:0] offset;
        logic [PAGE_BITS-1:0] count;
        logic [ORD_W-1:0]     order;
    } t_request;

    typedef struct {
        t_status              status;
        logic [PAGE_BITS-1:0] grant;
        logic [CNT_W-1:0]     in_use;
    } t_grant_result;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BASE;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_operation = 1'b0;
    logic [PAGE_BITS-1:0] i_requested_page_offset = '0;
    logic [PAGE_BITS-1:0] i_request_page_count = '0;
    logic [ORD_W-1:0]     i_align_order = '0;
    logic                 o_result_valid;
    logic [1:0]           o_status;
    logic [PAGE_BITS-1:0] o_granted_page_offset;
    logic [CNT_W-1:0]     o_ranges_in_use;

    address_range_allocator_top u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_operation             (i_operation),
        .i_requested_page_offset (i_requested_page_offset),
        .i_request_page_count    (i_request_page_count),
        .i_align_order           (i_align_order),
        .o_result_valid          (o_result_valid),
        .o_status                (o_status),
        .o_granted_page_offset   (o_granted_page_offset),
        .o_ranges_in_use         (o_ranges_in_use)
    );

    // 10 ns clock, high then low
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor state: region registers and the sorted range table
    // ------------------------------------------------------------------
    u64 pred_base = 0;
    u64 pred_size = SIZE_RESET;
    u64 pred_start [MAX_RANGES];
    u64 pred_len   [MAX_RANGES];
    int pred_count = 0;

    // walk stored ranges from the top down looking for the highest aligned gap
    function automatic bit gap_search(input u64 n, input u64 a, output u64 off);
        u64 top;
        u64 st;
        u64 en;
        u64 cand;
        int i;
        top = pred_size;
        off = 0;
        for (i = pred_count - 1; i >= 0; i--) begin
            st = pred_start[i];
            en = st + pred_len[i];
            if (top >= en && top - en >= n) begin
                cand = (pred_base + top - n) & ~(a - 1);
                if (cand >= pred_base + en) begin
                    off = cand - pred_base;
                    return 1'b1;
                end
            end
            if (st < top)
                top = st;
        end
        // the gap below the lowest stored range
        if (n <= top) begin
            cand = (pred_base + top - n) & ~(a - 1);
            if (cand >= pred_base) begin
                off = cand - pred_base;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit hits_stored(input u64 o, input u64 n);
        for (int i = 0; i < pred_count; i++)
            if (o < pred_start[i] + pred_len[i] && pred_start[i] < o + n)
                return 1'b1;
        return 1'b0;
    endfunction

    // keep the table in start order, equal starts go after the older range
    function automatic void store_range(input u64 o, input u64 n);
        int pos;
        pos = 0;
        while (pos < pred_count && pred_start[pos] <= o)
            pos++;
        for (int j = pred_count; j > pos; j--) begin
            pred_start[j] = pred_start[j-1];
            pred_len[j]   = pred_len[j-1];
        end
        pred_start[pos] = o;
        pred_len[pos]   = n;
        pred_count++;
    endfunction

    // expected outcome of one request, updating the predicted table
    function automatic t_grant_result place_request(input t_request r);
        t_grant_result res;
        u64 o;
        u64 n;
        u64 a;
        u64 g;
        t_status st;
        o  = u64'(r.offset);
        n  = u64'(r.count);
        a  = u64'(1) << r.order;
        g  = 0;
        st = STS_OK;
        if (n == 0) begin
            st = STS_INVALID;
        end else if (r.op) begin
            if (((pred_base + o) & (a - 1)) != 0 || o + n > pred_size || hits_stored(o, n))
                st = STS_INVALID;
            else
                g = o;
        end else begin
            if (!gap_search(n, a, g))
                st = STS_NO_GAP;
        end
        // a full table only shows once the placement itself is good
        if (st == STS_OK && pred_count >= MAX_RANGES)
            st = STS_FULL;
        if (st == STS_OK)
            store_range(g, n);
        else
            g = 0;
        res.status = st;
        res.grant  = g[PAGE_BITS-1:0];
        res.in_use = CNT_W'(pred_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping between stimulus, driver and monitor
    // ------------------------------------------------------------------
    t_request      pending_requests[$];
    t_grant_result awaited_grants[$];
    int            issued_count = 0;
    int            taken_count  = 0;
    int            fail_count   = 0;
    int            quiet_cycles = 0;
    logic          req_taken = 1'b0;
    logic          cfg_taken = 1'b0;

    // ------------------------------------------------------------------
    // driver: one request at a time from the pending queue, random gaps
    // ------------------------------------------------------------------
    int gap_left   = 0;
    bit burst_mode = 1'b0;

    always @(negedge i_clk) begin
        t_request r;
        logic     next_start;
        next_start = start;
        // request went in at the last rising edge
        if (start && req_taken)
            next_start = 1'b0;
        if (!next_start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                r = pending_requests.pop_front();
                i_operation             <= r.op;
                i_requested_page_offset <= r.offset;
                i_request_page_count    <= r.count;
                i_align_order           <= r.order;
                next_start = 1'b1;
                issued_count++;
                // alternate stretches of back-to-back requests with gappy ones
                if ($urandom_range(0, 39) == 0)
                    burst_mode = !burst_mode;
                gap_left = burst_mode ? 0 : $urandom_range(0, 6);
            end
        end
        start <= next_start;
    end

    // ------------------------------------------------------------------
    // monitor: predicts on acceptance, checks each result strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grant_result want;
        bit            moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            // results first: the previous request always finishes before the next is taken
            if (o_result_valid) begin
                moved = 1'b1;
                if (awaited_grants.size() == 0) begin
                    $display("%0t: result with nothing outstanding: status %0d offset %0h in use %0d",
                             $time, o_status, o_granted_page_offset, o_ranges_in_use);
                    fail_count++;
                end else begin
                    want = awaited_grants.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        fail_count++;
                    end
                    if (o_granted_page_offset !== want.grant) begin
                        $display("%0t: granted offset expected %0h actual %0h",
                                 $time, want.grant, o_granted_page_offset);
                        fail_count++;
                    end
                    if (o_ranges_in_use !== want.in_use) begin
                        $display("%0t: ranges in use expected %0d actual %0d",
                                 $time, want.in_use, o_ranges_in_use);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                t_request r;
                moved = 1'b1;
                r.op     = i_operation;
                r.offset = i_requested_page_offset;
                r.count  = i_request_page_count;
                r.order  = i_align_order;
                awaited_grants.push_back(place_request(r));
                taken_count++;
            end
            req_taken <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_BASE)
                    pred_base = u64'(i_cfg_data);
                else
                    pred_size = u64'(i_cfg_data);
            end
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            // watchdog on cycles with no handshake of any kind
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("address_range_allocator_top_test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [PAGE_BITS-1:0] any_pages();
        return PAGE_BITS'({$urandom, $urandom});
    endfunction

    function automatic t_request make_request(input bit op, input u64 off, input u64 cnt,
                                              input int ord);
        t_request r;
        r.op     = op;
        r.offset = off[PAGE_BITS-1:0];
        r.count  = cnt[PAGE_BITS-1:0];
        r.order  = ORD_W'(ord);
        return r;
    endfunction

    // mostly sane requests near the current region, with some raw noise
    function automatic t_request random_request(input u64 base, input u64 size);
        u64 off;
        u64 cnt;
        u64 a;
        int ord;
        int pick;
        ord  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            cnt = u64'($urandom_range(1, 256));
        else if (pick < 85)
            cnt = u64'(1) << $urandom_range(0, 22);
        else if (pick < 95)
            cnt = u64'(any_pages());
        else if (pick < 97)
            cnt = 0;
        else
            cnt = size;
        a = u64'(1) << ord;
        if ($urandom_range(0, 99) < 65 && size > 0) begin
            // offset somewhere inside the region, aligned when that does not go below zero
            off = u64'(any_pages()) % size;
            if (((base + off) & (a - 1)) <= off)
                off = off - ((base + off) & (a - 1));
        end else if ($urandom_range(0, 1) == 0) begin
            off = u64'($urandom_range(0, 4096));
        end else begin
            off = u64'(any_pages());
        end
        return make_request(1'($urandom_range(0, 1)), off, cnt, ord);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input u64 value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every outstanding request has its result
    task automatic drain();
        do @(negedge i_clk);
        while (pending_requests.size() > 0 || issued_count != taken_count ||
               awaited_grants.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input u64 base, input u64 size, input int items);
        drain();
        write_register(CFG_BASE, base);
        write_register(CFG_SIZE, size);
        for (int k = 0; k < items; k++)
            pending_requests.push_back(random_request(base, size));
        drain();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    localparam u64 PAGE_MAX = (u64'(1) << PAGE_BITS) - 1;

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset region, base 0 and 2^20 pages
        pending_requests.push_back(make_request(1'b0, 0, 0, 0));              // zero count, gap
        pending_requests.push_back(make_request(1'b1, 0, 0, 0));              // zero count, given
        pending_requests.push_back(make_request(1'b1, 0, 16, 4));             // bottom of region
        pending_requests.push_back(make_request(1'b1, 8, 4, 2));              // overlaps the one below
        pending_requests.push_back(make_request(1'b1, 18, 4, 2));             // misaligned
        pending_requests.push_back(make_request(1'b1, SIZE_RESET - 1, 1, 0)); // last page
        pending_requests.push_back(make_request(1'b1, SIZE_RESET - 4, 8, 0)); // runs past the end
        pending_requests.push_back(make_request(1'b1, PAGE_MAX, PAGE_MAX, 0));
        pending_requests.push_back(make_request(1'b0, 0, 100, 0));            // highest gap
        pending_requests.push_back(make_request(1'b0, 0, 100, 12));
        pending_requests.push_back(make_request(1'b0, 0, 1, 27));             // only 0 aligns, now taken
        pending_requests.push_back(make_request(1'b0, 0, 1, 31));             // order past the limit
        pending_requests.push_back(make_request(1'b0, 0, PAGE_MAX, 0));       // no gap
        pending_requests.push_back(make_request(1'b0, 0, SIZE_RESET, 0));     // whole region taken
        pending_requests.push_back(make_request(1'b0, 0, 64, 6));
        pending_requests.push_back(make_request(1'b1, 4096, 4096, 12));
        pending_requests.push_back(make_request(1'b1, 4096, 1, 0));           // inside the last one
        pending_requests.push_back(make_request(1'b1, 8192, 1, 0));           // touching, no overlap
        pending_requests.push_back(make_request(1'b1, 0, 1, 31));             // offset 0 aligns any order
        pending_requests.push_back(make_request(1'b0, 0, 3, 1));

        for (int k = 0; k < 160; k++)
            pending_requests.push_back(random_request(0, SIZE_RESET));
        drain();

        // unaligned base with the largest region
        run_phase(3, PAGE_MAX, 130);
        // empty region: nothing fits
        run_phase(0, 0, 60);
        // top base, region shrunk below many stored ranges
        run_phase(PAGE_MAX, 1000, 130);
        // power of two base, back to a mid-size region
        run_phase(u64'(1) << 31, SIZE_RESET, 200);

        if (fail_count == 0)
            $display("address_range_allocator_top_test passed");
        else
            $display("address_range_allocator_top_test failed");
        $finish;
    end

endmodule
